>>> rtl/pixel_alpha_compositor_macros.svh
// ----------------------------------------------------------------------------
// pixel_alpha_compositor_macros.svh
// Assertion macros for the pixel compositor. Empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PIXEL_ALPHA_COMPOSITOR_MACROS_SVH
`define PIXEL_ALPHA_COMPOSITOR_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, held off during reset
`define PAC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pixel compositor: same-cycle check failed");

// Next-cycle implication, held off during reset
`define PAC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pixel compositor: next-cycle check failed");

// Condition that must hold in the cycle after reset
`define PAC_ASSERT_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("pixel compositor: post-reset check failed");

`else

`define PAC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PAC_ASSERT_NEXT(label, clk, rst, ante, cons)
`define PAC_ASSERT_RESET(label, clk, rst, cons)

`endif

`endif

>>> rtl/pac_pkg.sv
// ----------------------------------------------------------------------------
// pac_pkg
// Shared widths, register indexes, control struct and the divide-by-255
// helper for the pixel compositor.
// ----------------------------------------------------------------------------
package pac_pkg;

   localparam int PIX_W      = 32;
   localparam int CHAN_W     = 8;
   localparam int NUM_CHAN   = 3;
   localparam int PROD_W     = 2 * CHAN_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CHAN_W-1:0] ALPHA_MAX = {CHAN_W{1'b1}};

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_TEST_ENABLE     = 2'd0;
   localparam csr_index_type CSR_BLEND_ENABLE    = 2'd1;
   localparam csr_index_type CSR_ALPHA_REFERENCE = 2'd2;

   // Per-beat decision carried down the pipe
   typedef struct packed {
      logic blend;   // result is the blended pixel
      logic write;   // frame buffer pixel is written
   } ctrl_type;

   typedef logic [NUM_CHAN-1:0][PROD_W-1:0] prod_vec_type;
   typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] chan_vec_type;

   // floor(x/255) for x up to 255*255: (x + (x >> 8) + 1) >> 8
   function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
      logic [PROD_W:0] sum;
      sum = {1'b0, x} + (PROD_W+1)'(x >> CHAN_W) + (PROD_W+1)'(1);
      return sum[CHAN_W +: CHAN_W];
   endfunction

endpackage

>>> rtl/pac_blend_pipe.sv
// ----------------------------------------------------------------------------
// pac_blend_pipe
// Three-stage blend datapath: per-channel products, divide by 255, then the
// channel sums and the output register. Each stage stalls only when full and
// blocked downstream.
// ----------------------------------------------------------------------------
module pac_blend_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [pac_pkg::PIX_W-1:0]     in_src,
   input  logic [pac_pkg::PIX_W-1:0]     in_opd,
   input  pac_pkg::ctrl_type             in_ctrl,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [pac_pkg::PIX_W-1:0]     out_pixel,
   output logic                          out_write
);
   import pac_pkg::*;

   logic                 b_valid_ff, c_valid_ff, d_valid_ff;
   logic                 rdy_b, rdy_c, rdy_d;
   ctrl_type             b_ctrl_ff, c_ctrl_ff;
   logic [PIX_W-1:0]     b_opd_ff, c_opd_ff, d_pixel_ff;
   logic                 d_write_ff;
   logic [CHAN_W-1:0]    b_alpha_ff, c_alpha_ff;
   prod_vec_type         b_sprod_in, b_dprod_in, b_sprod_ff, b_dprod_ff;
   chan_vec_type         c_squo_in, c_dquo_in, c_squo_ff, c_dquo_ff;
   logic [PIX_W-1:0]     d_pixel_in;
   logic [CHAN_W-1:0]    in_alpha, in_alpha_inv;

   // Stage readiness, back from the output register
   assign rdy_d    = !d_valid_ff || out_ready;
   assign rdy_c    = !c_valid_ff || rdy_d;
   assign rdy_b    = !b_valid_ff || rdy_c;
   assign in_ready = rdy_b;

   // Stage B: source and operand products per channel
   assign in_alpha     = in_src[PIX_W-1 -: CHAN_W];
   assign in_alpha_inv = ALPHA_MAX - in_alpha;

   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         b_sprod_in[i] = PROD_W'(in_src[i*CHAN_W +: CHAN_W]) * PROD_W'(in_alpha);
         b_dprod_in[i] = PROD_W'(in_opd[i*CHAN_W +: CHAN_W]) * PROD_W'(in_alpha_inv);
      end
   end

   // Stage C: divide each product by 255
   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         c_squo_in[i] = div255(b_sprod_ff[i]);
         c_dquo_in[i] = div255(b_dprod_ff[i]);
      end
   end

   // Stage D: channel sums or pass-through pixel
   always_comb begin
      if (c_ctrl_ff.blend) begin
         d_pixel_in[PIX_W-1 -: CHAN_W] = c_alpha_ff;
         for (int i = 0; i < NUM_CHAN; i++) begin
            d_pixel_in[i*CHAN_W +: CHAN_W] = c_squo_ff[i] + c_dquo_ff[i];
         end
      end else begin
         d_pixel_in = c_opd_ff;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (rdy_b) b_valid_ff <= in_valid;
         if (rdy_c) c_valid_ff <= b_valid_ff;
         if (rdy_d) d_valid_ff <= c_valid_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_valid && rdy_b) begin
         b_ctrl_ff  <= in_ctrl;
         b_opd_ff   <= in_opd;
         b_alpha_ff <= in_alpha;
         b_sprod_ff <= b_sprod_in;
         b_dprod_ff <= b_dprod_in;
      end
      if (b_valid_ff && rdy_c) begin
         c_ctrl_ff  <= b_ctrl_ff;
         c_opd_ff   <= b_opd_ff;
         c_alpha_ff <= b_alpha_ff;
         c_squo_ff  <= c_squo_in;
         c_dquo_ff  <= c_dquo_in;
      end
      if (c_valid_ff && rdy_d) begin
         d_pixel_ff <= d_pixel_in;
         d_write_ff <= c_ctrl_ff.write;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_pixel = d_pixel_ff;
   assign out_write = d_write_ff;

endmodule

>>> rtl/pixel_alpha_compositor.sv
// An accepted request beat passes through register stages A, B, C and D in turn.
// Throughput: one pixel per cycle while rsp_ready holds; four register stages,
// each holding one beat. A stalled response back-pressures stage by stage;
// empty stages keep filling. Reset (synchronous, active high) empties the pipe
// and clears all three configuration registers to zero.
// ----------------------------------------------------------------------------
// pixel_alpha_compositor
// Alpha test and source-over blend of ARGB8888 pixels, with a write flag.
// ----------------------------------------------------------------------------
module pixel_alpha_compositor (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [pac_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pac_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [pac_pkg::PIX_W-1:0]        req_source_pixel,
   input  logic [pac_pkg::PIX_W-1:0]        req_dest_pixel,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pac_pkg::PIX_W-1:0]        rsp_result_pixel,
   output logic                             rsp_write_flag
);
   import pac_pkg::*;

`include "pixel_alpha_compositor_macros.svh"

   logic               test_enable_ff, blend_enable_ff;
   logic [CHAN_W-1:0]  alpha_reference_ff;

   logic               a_valid_ff, rdy_a, pipe_in_ready;
   ctrl_type           a_ctrl_ff, a_ctrl_in;
   logic [PIX_W-1:0]   a_src_ff, a_opd_ff, a_opd_in;
   logic [CHAN_W-1:0]  req_alpha, threshold;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         test_enable_ff     <= 1'b0;
         blend_enable_ff    <= 1'b0;
         alpha_reference_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TEST_ENABLE:     test_enable_ff     <= csr_write_data[0];
            CSR_BLEND_ENABLE:    blend_enable_ff    <= csr_write_data[0];
            CSR_ALPHA_REFERENCE: alpha_reference_ff <= csr_write_data[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   // Stage A: alpha test and operand choice
   assign req_alpha = req_source_pixel[PIX_W-1 -: CHAN_W];
   assign threshold = test_enable_ff ? alpha_reference_ff : '0;

   always_comb begin
      a_ctrl_in.write = (req_alpha > threshold) || (!test_enable_ff && !blend_enable_ff);
      a_ctrl_in.blend = a_ctrl_in.write && blend_enable_ff;
      if (a_ctrl_in.blend) begin
         // with the test on, the written source blends over itself
         a_opd_in = test_enable_ff ? req_source_pixel : req_dest_pixel;
      end else begin
         a_opd_in = a_ctrl_in.write ? req_source_pixel : req_dest_pixel;
      end
   end

   assign rdy_a     = !a_valid_ff || pipe_in_ready;
   assign req_ready = rdy_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (rdy_a) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && rdy_a) begin
         a_ctrl_ff <= a_ctrl_in;
         a_src_ff  <= req_source_pixel;
         a_opd_ff  <= a_opd_in;
      end
   end

   // Blend datapath and output register
   pac_blend_pipe u_blend_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid_ff),
      .in_ready  (pipe_in_ready),
      .in_src    (a_src_ff),
      .in_opd    (a_opd_ff),
      .in_ctrl   (a_ctrl_ff),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_pixel (rsp_result_pixel),
      .out_write (rsp_write_flag)
   );

   // Checks
   `PAC_ASSERT_RESET(a_reset_empty, clock, reset, !rsp_valid && !a_valid_ff)
   `PAC_ASSERT_IMPL(a_empty_out_accepts, clock, reset, !rsp_valid, req_ready)
   `PAC_ASSERT_IMPL(a_blend_implies_write, clock, reset,
                    a_valid_ff && a_ctrl_ff.blend, a_ctrl_ff.write)
   `PAC_ASSERT_NEXT(a_stage_a_holds, clock, reset,
                    a_valid_ff && !pipe_in_ready, a_valid_ff && $stable(a_opd_ff))

endmodule

>>> bench/pixel_alpha_compositor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_alpha_compositor_tb
// Self-checking bench for the alpha test / blend compositor. A directed
// table covers the mode corners and threshold edges, then random pixel beats
// run under a series of register settings. Both handshake sides idle in
// random bursts, and one phase holds the response side off long enough to
// back the pipe up into the request side. Every response beat is compared with
// the row's given value or with the bench's own model of the compositor.
// ----------------------------------------------------------------------------
module pixel_alpha_compositor_tb;
   import pac_pkg::*;

   localparam int CLK_HALF       = 5;
   localparam int RESET_CYCLES   = 12;
   localparam int SETTLE_CYCLES  = 8;    // slack after the pipe drains
   localparam int HOLD_CYCLES    = 64;   // long response hold-off
   localparam int NUM_PHASES     = 10;
   localparam int BEATS_PER_PHASE = 105;
   localparam int NUM_ROWS       = 19;

   // index past the register list; writes there must be dropped
   localparam csr_index_type CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             wr;
   } pixel_result_type;

   typedef struct packed {
      logic              te;
      logic              be;
      logic [CHAN_W-1:0] aref;
      logic [PIX_W-1:0]  src;
      logic [PIX_W-1:0]  dst;
      logic              typed;     // expected value given in the row
      logic [PIX_W-1:0]  exp_pixel;
      logic              exp_wr;
   } directed_row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   logic                   req_valid;
   logic                   req_ready;
   logic [PIX_W-1:0]       req_source_pixel;
   logic [PIX_W-1:0]       req_dest_pixel;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [PIX_W-1:0]       rsp_result_pixel;
   logic                   rsp_write_flag;

   // bench copy of the register file
   logic                   cfg_test_enable;
   logic                   cfg_blend_enable;
   logic [CHAN_W-1:0]      cfg_alpha_reference;

   pixel_result_type       expected_pixels[$];
   directed_row_type       rows[NUM_ROWS];
   int                     error_count;
   bit                     idle_on;
   bit                     hold_request;
   int                     rsp_stall_left;

   pixel_alpha_compositor dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_source_pixel (req_source_pixel),
      .req_dest_pixel   (req_dest_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_pixel (rsp_result_pixel),
      .rsp_write_flag   (rsp_write_flag)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // run limit, far above the slowest legal run
   initial begin
      #5_000_000;
      $display("** pixel_alpha_compositor: FAILED **");
      $finish;
   end

   // one channel: floor(s*a/255) + floor(d*(255-a)/255)
   function automatic logic [PIX_W-1:0] blend_over(input logic [PIX_W-1:0] s,
                                                   input logic [PIX_W-1:0] d,
                                                   input logic [CHAN_W-1:0] a);
      logic [PIX_W-1:0] out;
      int unsigned      sc, dc, av, sum;
      out = '0;
      out[PIX_W-1 -: CHAN_W] = a;
      av = 32'(a);
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         sc  = 32'(s[ch*CHAN_W +: CHAN_W]);
         dc  = 32'(d[ch*CHAN_W +: CHAN_W]);
         sum = (sc * av) / 255 + (dc * (255 - av)) / 255;
         out[ch*CHAN_W +: CHAN_W] = sum[CHAN_W-1:0];
      end
      return out;
   endfunction

   // expected response for one request beat under the current settings
   function automatic pixel_result_type composite_pixel(input logic [PIX_W-1:0] src,
                                                        input logic [PIX_W-1:0] dst);
      pixel_result_type  r;
      logic [CHAN_W-1:0] a;
      a       = src[PIX_W-1 -: CHAN_W];
      r.pixel = dst;
      r.wr    = 1'b0;
      if (cfg_test_enable) begin
         if (a > cfg_alpha_reference) begin
            r.pixel = cfg_blend_enable ? blend_over(src, src, a) : src;
            r.wr    = 1'b1;
         end
      end else if (cfg_blend_enable) begin
         if (a != '0) begin
            r.pixel = blend_over(src, dst, a);
            r.wr    = 1'b1;
         end
      end else begin
         r.pixel = src;
         r.wr    = 1'b1;
      end
      return r;
   endfunction

   // one register write beat, driven on the falling edge
   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
   endtask

   // program all registers; junk goes into unused upper bits and the unmapped index
   task automatic program_settings(input logic te, input logic be,
                                   input logic [CHAN_W-1:0] aref);
      logic [CSR_DATA_W-2:0] junk_te, junk_be;
      logic [CSR_DATA_W-1:0] junk_idx;
      junk_te  = (CSR_DATA_W-1)'($urandom);
      junk_be  = (CSR_DATA_W-1)'($urandom);
      junk_idx = CSR_DATA_W'($urandom);
      csr_write(CSR_UNMAPPED, junk_idx);
      csr_write(CSR_TEST_ENABLE, {junk_te, te});
      csr_write(CSR_BLEND_ENABLE, {junk_be, be});
      csr_write(CSR_ALPHA_REFERENCE, aref);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      cfg_test_enable     = te;
      cfg_blend_enable    = be;
      cfg_alpha_reference = aref;
   endtask

   // drop valid and wait until the pipe is empty
   task automatic settle_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // offer one request beat, optionally after an idle burst
   task automatic offer_pixel(input logic [PIX_W-1:0] src, input logic [PIX_W-1:0] dst,
                              input logic typed, input pixel_result_type typed_exp);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_source_pixel <= src;
      req_dest_pixel   <= dst;
      do @(posedge clock); while (!req_ready);
      expected_pixels.push_back(typed ? typed_exp : composite_pixel(src, dst));
   endtask

   // response side: random stall bursts, plus the long hold-off on request
   initial begin
      rsp_ready      = 1'b0;
      rsp_stall_left = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_request = 1'b0;
         end else if (rsp_stall_left > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0)
               rsp_stall_left = $urandom_range(1, 8);
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      pixel_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: response beat with nothing expected: pixel %h flag %b",
                     $time, rsp_result_pixel, rsp_write_flag);
            error_count++;
         end else begin
            e = expected_pixels.pop_front();
            if (rsp_result_pixel !== e.pixel) begin
               $display("%0t: result_pixel expected %h actual %h",
                        $time, e.pixel, rsp_result_pixel);
               error_count++;
            end
            if (rsp_write_flag !== e.wr) begin
               $display("%0t: write_flag expected %b actual %b",
                        $time, e.wr, rsp_write_flag);
               error_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      pixel_result_type  typed_exp;
      logic [PIX_W-1:0]  src, dst;
      logic [CHAN_W-1:0] alpha, aref;
      logic              te, be;

      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_source_pixel = '0;
      req_dest_pixel   = '0;
      cfg_test_enable     = 1'b0;
      cfg_blend_enable    = 1'b0;
      cfg_alpha_reference = '0;
      error_count  = 0;
      idle_on      = 1'b1;
      hold_request = 1'b0;

      // directed table: te be aref src dst typed exp_pixel exp_wr
      rows[0]  = '{1'b0, 1'b0, 8'h00, 32'hFFFFFFFF, 32'h00000000, 1'b1, 32'hFFFFFFFF, 1'b1};
      rows[1]  = '{1'b0, 1'b0, 8'h00, 32'h00000000, 32'hFFFFFFFF, 1'b1, 32'h00000000, 1'b1};
      rows[2]  = '{1'b0, 1'b0, 8'h00, 32'h5A3C96E1, 32'h0F0F0F0F, 1'b0, 32'h0, 1'b0};
      // threshold test: alpha equal to the reference is not written
      rows[3]  = '{1'b1, 1'b0, 8'h80, 32'h80123456, 32'hCAFEBABE, 1'b1, 32'hCAFEBABE, 1'b0};
      rows[4]  = '{1'b1, 1'b0, 8'h80, 32'h81123456, 32'hCAFEBABE, 1'b1, 32'h81123456, 1'b1};
      rows[5]  = '{1'b1, 1'b0, 8'hFF, 32'hFFFFFFFF, 32'h00000000, 1'b1, 32'h00000000, 1'b0};
      rows[6]  = '{1'b1, 1'b0, 8'h00, 32'h00FFFFFF, 32'h12345678, 1'b1, 32'h12345678, 1'b0};
      rows[7]  = '{1'b1, 1'b0, 8'h00, 32'h01000000, 32'hFFFFFFFF, 1'b1, 32'h01000000, 1'b1};
      // blend only: zero alpha keeps dest, full alpha gives the source
      rows[8]  = '{1'b0, 1'b1, 8'h00, 32'h00ABCDEF, 32'h55AA55AA, 1'b1, 32'h55AA55AA, 1'b0};
      rows[9]  = '{1'b0, 1'b1, 8'h00, 32'hFF123456, 32'h00ABCDEF, 1'b1, 32'hFF123456, 1'b1};
      rows[10] = '{1'b0, 1'b1, 8'h00, 32'h01FFFFFF, 32'h00FFFFFF, 1'b0, 32'h0, 1'b0};
      rows[11] = '{1'b0, 1'b1, 8'h00, 32'h80FFFFFF, 32'hFF000000, 1'b0, 32'h0, 1'b0};
      rows[12] = '{1'b0, 1'b1, 8'h00, 32'h7F000000, 32'h00FFFFFF, 1'b0, 32'h0, 1'b0};
      rows[13] = '{1'b0, 1'b1, 8'h00, 32'h80FF00FF, 32'h0000FF00, 1'b0, 32'h0, 1'b0};
      // test and blend: source blended over itself
      rows[14] = '{1'b1, 1'b1, 8'h10, 32'h10FFFFFF, 32'h76543210, 1'b1, 32'h76543210, 1'b0};
      rows[15] = '{1'b1, 1'b1, 8'h10, 32'h11FFFFFF, 32'h00000000, 1'b0, 32'h0, 1'b0};
      rows[16] = '{1'b1, 1'b1, 8'h00, 32'hFF808080, 32'h00000000, 1'b1, 32'hFF808080, 1'b1};
      rows[17] = '{1'b1, 1'b1, 8'hFE, 32'hFF7F01FE, 32'h12345678, 1'b0, 32'h0, 1'b0};
      rows[18] = '{1'b1, 1'b1, 8'h00, 32'h80FFFFFF, 32'h00000000, 1'b0, 32'h0, 1'b0};

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      for (int i = 0; i < NUM_ROWS; i++) begin
         if (rows[i].te !== cfg_test_enable || rows[i].be !== cfg_blend_enable ||
             rows[i].aref !== cfg_alpha_reference) begin
            settle_pipeline();
            program_settings(rows[i].te, rows[i].be, rows[i].aref);
         end
         typed_exp.pixel = rows[i].exp_pixel;
         typed_exp.wr    = rows[i].exp_wr;
         offer_pixel(rows[i].src, rows[i].dst, rows[i].typed, typed_exp);
      end

      // random phases, each under its own settings
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin te = 1'b1; be = 1'b0; aref = 8'h00; end
            1: begin te = 1'b1; be = 1'b1; aref = 8'hFF; end
            2: begin te = 1'b0; be = 1'b1; aref = CHAN_W'($urandom); end
            3: begin te = 1'b1; be = 1'b1; aref = 8'h00; end
            4: begin te = 1'b1; be = 1'b0; aref = 8'hFF; end
            5: begin te = 1'b0; be = 1'b0; aref = CHAN_W'($urandom); end
            default: begin
               te   = 1'($urandom_range(0, 1));
               be   = 1'($urandom_range(0, 1));
               aref = CHAN_W'($urandom);
            end
         endcase
         settle_pipeline();
         program_settings(te, be, aref);
         idle_on = (p != NUM_PHASES - 1);
         if (p == 2) hold_request = 1'b1;

         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            // alpha lands on the threshold edges often
            case ($urandom_range(0, 7))
               0: alpha = 8'h00;
               1: alpha = 8'hFF;
               2: alpha = cfg_alpha_reference;
               3: alpha = cfg_alpha_reference + 8'd1;
               4: alpha = cfg_alpha_reference - 8'd1;
               default: alpha = CHAN_W'($urandom);
            endcase
            src = $urandom;
            dst = $urandom;
            case ($urandom_range(0, 7))
               0: src[PIX_W-CHAN_W-1:0] = '1;
               1: src[PIX_W-CHAN_W-1:0] = '0;
               2: dst = '1;
               3: dst = '0;
               default: ;
            endcase
            src[PIX_W-1 -: CHAN_W] = alpha;
            offer_pixel(src, dst, 1'b0, typed_exp);
         end
      end

      // drain and report
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("** pixel_alpha_compositor: PASSED **");
      end else begin
         $display("** pixel_alpha_compositor: FAILED **");
      end
      $finish;
   end

endmodule
